/* hdl/vfcm_pkg.sv */
package vfcm_pkg;

   localparam int SIDE_DEF = 32;
   localparam int WORD_W   = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;

   typedef enum logic [1:0] {
      CMD_COLUMN   = 2'd0,
      CMD_TYPE     = 2'd1,
      CMD_NEIGHBOR = 2'd2,
      CMD_MESH     = 2'd3
   } cmd_type;

   localparam logic [2:0] SIDE_ABOVE = 3'd0;
   localparam logic [2:0] SIDE_BELOW = 3'd1;
   localparam logic [2:0] SIDE_MX    = 3'd2;
   localparam logic [2:0] SIDE_PX    = 3'd3;
   localparam logic [2:0] SIDE_PZ    = 3'd4;
   localparam logic [2:0] SIDE_MZ    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SUBCHUNK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT  = 1'd1;

   typedef struct packed {
      logic [4:0] pos_x;
      logic [4:0] pos_y;
      logic [4:0] pos_z;
      logic [7:0] vtype;
      logic [7:0] base;
      logic [5:0] faces;
   } job_type;

   // corner offsets {dx,dy,dz} for face f, vertex v
   function automatic logic [2:0] corner(input logic [2:0] f, input logic [2:0] v);
      logic [17:0] row;
      unique case (f)
         3'd0: row = {3'b011, 3'b111, 3'b110, 3'b110, 3'b010, 3'b011};
         3'd1: row = {3'b000, 3'b100, 3'b101, 3'b101, 3'b001, 3'b000};
         3'd2: row = {3'b000, 3'b001, 3'b011, 3'b011, 3'b010, 3'b000};
         3'd3: row = {3'b101, 3'b100, 3'b110, 3'b110, 3'b111, 3'b101};
         3'd4: row = {3'b001, 3'b101, 3'b111, 3'b111, 3'b011, 3'b001};
         3'd5: row = {3'b100, 3'b000, 3'b010, 3'b010, 3'b110, 3'b100};
         default: row = '0;
      endcase
      unique case (v)
         3'd0: corner = row[17:15];
         3'd1: corner = row[14:12];
         3'd2: corner = row[11:9];
         3'd3: corner = row[8:6];
         3'd4: corner = row[5:3];
         3'd5: corner = row[2:0];
         default: corner = '0;
      endcase
   endfunction

endpackage

/* hdl/vfcm_req_if.sv */
interface vfcm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [4:0]  pos_x;
   logic [4:0]  pos_y;
   logic [4:0]  pos_z;
   logic [2:0]  side;
   logic [31:0] word;
   logic [7:0]  voxel_type;
   modport source (output valid, command, pos_x, pos_y, pos_z, side, word, voxel_type,
                   input ready);
   modport sink (input valid, command, pos_x, pos_y, pos_z, side, word, voxel_type,
                 output ready);
endinterface

interface vfcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] vertex_word;
   logic        last;
   modport source (output valid, vertex_word, last, input ready);
   modport sink (input valid, vertex_word, last, output ready);
endinterface

/* hdl/vfcm_store.sv */
module vfcm_store #(
   parameter int SIDE = vfcm_pkg::SIDE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   vfcm_req_if.sink           req,
   input  logic [2:0]         subchunk_index,
   input  logic [3:0]         side_present,
   input  logic               job_ready,
   output logic               job_valid,
   output vfcm_pkg::job_type  job
);
   import vfcm_pkg::*;

   localparam int CW = $clog2(SIDE);
   localparam int AW = 2 * CW;
   localparam int TW = 3 * CW;
   localparam int DEPTH = SIDE * SIDE;

   logic [SIDE-1:0] col_mem [DEPTH];
   logic [SIDE-1:0] colm_mem [DEPTH];
   logic [SIDE-1:0] colp_mem [DEPTH];
   logic [SIDE-1:0] colzm_mem [DEPTH];
   logic [SIDE-1:0] colzp_mem [DEPTH];
   logic [7:0]      type_mem [SIDE*SIDE*SIDE];
   logic            above_mem [DEPTH];
   logic            below_mem [DEPTH];
   logic [SIDE-1:0] mx_mem [SIDE];
   logic [SIDE-1:0] px_mem [SIDE];
   logic [SIDE-1:0] pz_mem [SIDE];
   logic [SIDE-1:0] mz_mem [SIDE];

   logic ok_x, ok_y, ok_z, acc;
   logic [CW-1:0] x, y, z;
   logic [AW-1:0] a;
   logic [SIDE-1:0] w;

   assign ok_x = 32'(req.pos_x) < SIDE;
   assign ok_y = 32'(req.pos_y) < SIDE;
   assign ok_z = 32'(req.pos_z) < SIDE;
   assign x = req.pos_x[CW-1:0];
   assign y = req.pos_y[CW-1:0];
   assign z = req.pos_z[CW-1:0];
   assign a = {z, x};
   assign w = req.word[SIDE-1:0];

   logic s1_valid_ff, s1_valid_in;
   logic s1_ok_ff;
   logic [CW-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [SIDE-1:0] c_ff, cm_ff, cp_ff, czm_ff, czp_ff, emx_ff, epx_ff, epz_ff, emz_ff;
   logic ab_ff, bl_ff;
   logic [7:0] t_ff;

   assign req.ready = ~s1_valid_ff | job_ready;
   assign acc = req.valid & req.ready;

   // neighbour columns kept as copies, written at the shifted address
   always_ff @(posedge clock) begin
      if (acc && req.command == CMD_COLUMN && ok_x && ok_z) begin
         col_mem[a] <= w;
         if (32'(x) + 1 < SIDE) colm_mem[{z, x + CW'(1)}] <= w;
         if (x != '0) colp_mem[{z, x - CW'(1)}] <= w;
         if (z != '0) colzp_mem[{z - CW'(1), x}] <= w;
         if (32'(z) + 1 < SIDE) colzm_mem[{z + CW'(1), x}] <= w;
      end
      if (acc && req.command == CMD_TYPE && ok_x && ok_y && ok_z)
         type_mem[{y, z, x}] <= req.voxel_type;
      if (acc && req.command == CMD_NEIGHBOR) begin
         if (req.side == SIDE_ABOVE && ok_x && ok_z) above_mem[a] <= w[0];
         if (req.side == SIDE_BELOW && ok_x && ok_z) below_mem[a] <= w[SIDE-1];
         if (req.side == SIDE_MX && ok_z) mx_mem[z] <= w;
         if (req.side == SIDE_PX && ok_z) px_mem[z] <= w;
         if (req.side == SIDE_PZ && ok_x) pz_mem[x] <= w;
         if (req.side == SIDE_MZ && ok_x) mz_mem[x] <= w;
      end
      if (req.ready) begin
         c_ff   <= col_mem[a];
         cm_ff  <= colm_mem[a];
         cp_ff  <= colp_mem[a];
         czm_ff <= colzm_mem[a];
         czp_ff <= colzp_mem[a];
         ab_ff  <= above_mem[a];
         bl_ff  <= below_mem[a];
         emx_ff <= mx_mem[z];
         epx_ff <= px_mem[z];
         epz_ff <= pz_mem[x];
         emz_ff <= mz_mem[x];
         t_ff   <= type_mem[{y, z, x}];
         s1_x_ff <= x;
         s1_y_ff <= y;
         s1_z_ff <= z;
         s1_ok_ff <= ok_x & ok_y & ok_z;
      end
   end

   assign s1_valid_in = req.ready ? (acc && req.command == CMD_MESH) : s1_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= s1_valid_in;
   end

   logic [SIDE-1:0] m0, m1, m2, m3, m4, m5, top;
   logic xl, xh, zl, zh;
   assign top = {1'b1, {(SIDE-1){1'b0}}};
   assign xl = s1_x_ff == '0;
   assign xh = s1_x_ff == CW'(SIDE-1);
   assign zl = s1_z_ff == '0;
   assign zh = s1_z_ff == CW'(SIDE-1);
   always_comb begin
      m0 = ~(c_ff >> 1) & c_ff & ~(ab_ff ? top : '0);
      m1 = ~(c_ff << 1) & c_ff & ~{{(SIDE-1){1'b0}}, bl_ff};
      m2 = ~(xl ? '0 : cm_ff) & c_ff;
      m3 = ~(xh ? '0 : cp_ff) & c_ff;
      m4 = ~(zh ? '0 : czp_ff) & c_ff;
      m5 = ~(zl ? '0 : czm_ff) & c_ff;
      if (xl && side_present[0]) m2 = m2 & ~emx_ff;
      if (xh && side_present[1]) m3 = m3 & ~epx_ff;
      if (zh && side_present[2]) m4 = m4 & ~epz_ff;
      if (zl && side_present[3]) m5 = m5 & ~emz_ff;
   end

   logic [5:0] faces;
   assign faces = {m5[s1_y_ff], m4[s1_y_ff], m3[s1_y_ff], m2[s1_y_ff],
                   m1[s1_y_ff], m0[s1_y_ff]} & {6{c_ff[s1_y_ff] & s1_ok_ff}};

   assign job_valid = s1_valid_ff;
   assign job.pos_x = 5'(s1_x_ff);
   assign job.pos_y = 5'(s1_y_ff);
   assign job.pos_z = 5'(s1_z_ff);
   assign job.vtype = t_ff;
   assign job.base  = 8'(s1_y_ff) + 8'(32'(subchunk_index) * SIDE);
   assign job.faces = faces;
endmodule

/* hdl/vfcm_emit.sv */
module vfcm_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  vfcm_pkg::job_type  job,
   vfcm_rsp_if.source         rsp
);
   import vfcm_pkg::*;

   logic busy_ff, busy_in;
   job_type j_ff, j_in;
   logic [5:0] left_ff, left_in;
   logic [2:0] v_ff, v_in;
   logic [2:0] f;
   logic [5:0] rest;
   logic [2:0] c;
   logic fire, fin, is_last;

   always_comb begin
      f = 3'd0;
      for (int i = 5; i >= 0; i--) if (left_ff[i]) f = 3'(i);
   end
   assign rest = left_ff & ~(6'd1 << f);
   assign c = corner(f, v_ff);
   assign is_last = (v_ff == 3'd5) && (rest == '0);

   logic ov_ff, ov_in;
   logic [31:0] ow_ff, ow_in;
   logic ol_ff, ol_in;
   assign fire = busy_ff & (~ov_ff | rsp.ready);
   assign fin = fire & is_last;
   assign job_ready = ~busy_ff | fin;

   always_comb begin
      busy_in = busy_ff;
      j_in = j_ff;
      left_in = left_ff;
      v_in = v_ff;
      ov_in = ov_ff & ~rsp.ready;
      ow_in = ow_ff;
      ol_in = ol_ff;
      if (fire) begin
         ov_in = 1'b1;
         ow_in = {8'(j_ff.pos_x) + 8'(c[2]), j_ff.base + 8'(c[1]),
                  8'(j_ff.pos_z) + 8'(c[0]), j_ff.vtype};
         ol_in = is_last;
         if (v_ff == 3'd5) begin
            v_in = 3'd0;
            left_in = rest;
         end else begin
            v_in = v_ff + 3'd1;
         end
         if (is_last) busy_in = 1'b0;
      end
      if (job_ready && job_valid && job.faces != '0) begin
         busy_in = 1'b1;
         j_in = job;
         left_in = job.faces;
         v_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff <= ov_in;
      end
      j_ff <= j_in;
      left_ff <= left_in;
      v_ff <= v_in;
      ow_ff <= ow_in;
      ol_ff <= ol_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.vertex_word = ow_ff;
   assign rsp.last = ol_ff;
endmodule

/* hdl/voxel_face_culling_mesher_top.sv */
// Voxel face-culling mesher for one subchunk.
// req: load and mesh commands (column, voxel type, neighbour word, mesh).
// rsp: packed vertices x<<24|y<<16|z<<8|type, last marks a voxel's final one.
// csr: write-only registers, index 0 subchunk_index, 1 side_present.
// Load commands are taken one per cycle while req.ready is high and return nothing.
// A mesh command reads all stores in one synchronous memory access,
// forms six face masks, then emits six vertices per exposed face, one per
// cycle while rsp is ready. A voxel with no exposed face emits no vertex.
// The next command is accepted while vertices stream, unless a mesh
// command already waits in the store stage.
// Reset clears control state and the CSR registers; stores are undefined until loaded.
// A stalled rsp holds its item and the pipeline stops behind it.
module voxel_face_culling_mesher_top #(
   parameter int SIDE = vfcm_pkg::SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   vfcm_req_if.sink                          req,
   vfcm_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [vfcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vfcm_pkg::CSR_DAT_W-1:0]    csr_write_data
);
   import vfcm_pkg::*;

   logic [2:0] sub_ff;
   logic [3:0] pres_ff;
   logic job_valid, job_ready;
   job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
         pres_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SUBCHUNK: sub_ff <= csr_write_data[2:0];
            CSR_PRESENT:  pres_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   vfcm_store #(.SIDE(SIDE)) u_store (
      .clock, .reset, .req,
      .subchunk_index(sub_ff), .side_present(pres_ff),
      .job_ready, .job_valid, .job
   );

   vfcm_emit u_emit (
      .clock, .reset, .job_valid, .job_ready, .job, .rsp
   );
endmodule

/* bench/tb_top.sv */
module tb_top;
   import vfcm_pkg::*;

   typedef struct {
      bit [31:0] vertex;
      bit        last;
   } vertex_item;

   class mesher_scoreboard;
      bit [2:0]   subchunk;
      bit [3:0]   present;
      bit [31:0]  columns [1024];
      bit [7:0]   materials [32768];
      bit         typed [32768];
      bit         above_bits [1024];
      bit         below_bits [1024];
      bit [31:0]  rim_mx [32];
      bit [31:0]  rim_px [32];
      bit [31:0]  rim_pz [32];
      bit [31:0]  rim_mz [32];
      vertex_item pending [$];
      int         errors;
      int         vertices;
      int         meshes;

      function void set_register(bit idx, bit [3:0] data);
         if (idx == CSR_SUBCHUNK) subchunk = data[2:0];
         else present = data;
      endfunction

      function void note_item(cmd_type c, bit [4:0] x, bit [4:0] y, bit [4:0] z,
                              bit [2:0] s, bit [31:0] w, bit [7:0] t);
         bit [2:0]   offs [0:5][0:5];
         bit [31:0]  m [6];
         bit [31:0]  col;
         bit [7:0]   base, vx, vy, vz;
         bit [2:0]   o;
         int         idx, n;
         vertex_item vi;
         offs = '{'{3'b011, 3'b111, 3'b110, 3'b110, 3'b010, 3'b011},
                  '{3'b000, 3'b100, 3'b101, 3'b101, 3'b001, 3'b000},
                  '{3'b000, 3'b001, 3'b011, 3'b011, 3'b010, 3'b000},
                  '{3'b101, 3'b100, 3'b110, 3'b110, 3'b111, 3'b101},
                  '{3'b001, 3'b101, 3'b111, 3'b111, 3'b011, 3'b001},
                  '{3'b100, 3'b000, 3'b010, 3'b010, 3'b110, 3'b100}};
         idx = x + z * 32;
         case (c)
            CMD_COLUMN: columns[idx] = w;
            CMD_TYPE: begin
               materials[(y * 32 + z) * 32 + x] = t;
               typed[(y * 32 + z) * 32 + x] = 1'b1;
            end
            CMD_NEIGHBOR: begin
               case (s)
                  SIDE_ABOVE: above_bits[idx] = w[0];
                  SIDE_BELOW: below_bits[idx] = w[31];
                  SIDE_MX: rim_mx[z] = w;
                  SIDE_PX: rim_px[z] = w;
                  SIDE_PZ: rim_pz[x] = w;
                  SIDE_MZ: rim_mz[x] = w;
                  default: ;
               endcase
            end
            CMD_MESH: begin
               meshes++;
               col = columns[idx];
               if (!col[y]) return;
               m[0] = ~(col >> 1) & col & ~(above_bits[idx] ? 32'h8000_0000 : 32'h0);
               m[1] = ~(col << 1) & col & ~{31'b0, below_bits[idx]};
               m[2] = ~(x > 0 ? columns[idx - 1] : 32'h0) & col;
               m[3] = ~(x < 31 ? columns[idx + 1] : 32'h0) & col;
               m[4] = ~(z < 31 ? columns[idx + 32] : 32'h0) & col;
               m[5] = ~(z > 0 ? columns[idx - 32] : 32'h0) & col;
               if (x == 0 && present[0]) m[2] &= ~rim_mx[z];
               if (x == 31 && present[1]) m[3] &= ~rim_px[z];
               if (z == 31 && present[2]) m[4] &= ~rim_pz[x];
               if (z == 0 && present[3]) m[5] &= ~rim_mz[x];
               base = 8'(y + subchunk * 32);
               n = 0;
               for (int f = 0; f < 6; f++) begin
                  if (!m[f][y]) continue;
                  for (int v = 0; v < 6; v++) begin
                     o = offs[f][v];
                     vx = 8'(x) + 8'(o[2]);
                     vy = base + 8'(o[1]);
                     vz = 8'(z) + 8'(o[0]);
                     vi.vertex = {vx, vy, vz, materials[(y * 32 + z) * 32 + x]};
                     vi.last = 0;
                     pending = {pending, vi};
                     n++;
                  end
               end
               if (n > 0) pending[pending.size() - 1].last = 1;
            end
         endcase
      endfunction

      function void check_vertex(bit [31:0] word, bit last);
         vertex_item e;
         vertices++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected vertex %h last %b", word, last);
            return;
         end
         e = pending.pop_front();
         if (e.vertex !== word || e.last !== last) begin
            errors++;
            if (errors <= 10)
               $display("vertex mismatch: expected %h last %b, got %h last %b",
                        e.vertex, e.last, word, last);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;
   bit         no_idle;
   int         rsp_hold;
   int         rsp_count;
   int         rsp_seen;
   longint     cycles;
   mesher_scoreboard sb;

   vfcm_req_if req_bus ();
   vfcm_rsp_if rsp_bus ();

   voxel_face_culling_mesher_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 11);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 0;
      end else begin
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            rsp_hold = draw_gap();
         end
         if (rsp_hold > 0) begin
            rsp_bus.ready = 0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_bus.ready = 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_vertex(rsp_bus.vertex_word, rsp_bus.last);
         rsp_count = rsp_count + 1;
      end
   end

   task automatic send(cmd_type c, bit [4:0] x, bit [4:0] y, bit [4:0] z,
                       bit [2:0] s, bit [31:0] w, bit [7:0] t);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.command = c;
      req_bus.pos_x = x;
      req_bus.pos_y = y;
      req_bus.pos_z = z;
      req_bus.side = s;
      req_bus.word = w;
      req_bus.voxel_type = t;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(c, x, y, z, s, w, t);
      @(negedge clock);
   endtask

   task automatic mesh(bit [4:0] x, bit [4:0] y, bit [4:0] z);
      if (!sb.typed[(y * 32 + z) * 32 + x])
         send(CMD_TYPE, x, y, z, SIDE_ABOVE, 32'h0, 8'($urandom));
      send(CMD_MESH, x, y, z, 3'($urandom), $urandom, 8'($urandom));
   endtask

   task automatic go_quiet();
      req_bus.valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(bit idx, bit [3:0] data);
      go_quiet();
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 0;
      sb.set_register(idx, data);
   endtask

   function automatic bit [31:0] column_pattern();
      case ($urandom_range(0, 5))
         0: return $urandom & $urandom;
         1: return $urandom | $urandom;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // loaded band: 0..2 and 29..31
   function automatic bit [4:0] band_pos(int i);
      return 5'(i < 3 ? i : i + 26);
   endfunction

   // mesh targets: 0, 1, 30, 31
   function automatic bit [4:0] core_pos(int i);
      return 5'(i < 2 ? i : i + 28);
   endfunction

   task automatic random_item();
      bit [4:0] x, y, z;
      int tries;
      x = 5'($urandom);
      y = 5'($urandom);
      z = 5'($urandom);
      case ($urandom_range(0, 9))
         0, 1: send(CMD_COLUMN, x, y, z, 3'($urandom), column_pattern(), 8'($urandom));
         2: send(CMD_TYPE, x, y, z, 3'($urandom), $urandom, 8'($urandom));
         3: send(CMD_NEIGHBOR, x, y, z, 3'($urandom), $urandom, 8'($urandom));
         default: begin
            x = core_pos($urandom_range(0, 3));
            z = core_pos($urandom_range(0, 3));
            tries = 0;
            while (sb.columns[x + z * 32] != 0 && !sb.columns[x + z * 32][y] &&
                   tries < 64) begin
               y = 5'($urandom);
               tries++;
            end
            mesh(x, y, z);
         end
      endcase
   endtask

   initial begin
      bit [3:0] phase_cfg [6][2];
      sb = new();
      no_idle = 1;
      reset = 1;
      csr_write_enable = 0;
      csr_index = CSR_SUBCHUNK;
      csr_write_data = 0;
      req_bus.valid = 0;
      req_bus.command = CMD_COLUMN;
      req_bus.pos_x = 0;
      req_bus.pos_y = 0;
      req_bus.pos_z = 0;
      req_bus.side = SIDE_ABOVE;
      req_bus.word = 0;
      req_bus.voxel_type = 0;
      repeat (12) @(negedge clock);
      reset = 0;

      // load every entry that a mesh can read
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 6; j++) begin
            send(CMD_COLUMN, band_pos(i), 5'($urandom), band_pos(j), 3'($urandom),
                 column_pattern(), 8'($urandom));
            send(CMD_NEIGHBOR, band_pos(i), 5'($urandom), band_pos(j), SIDE_ABOVE,
                 $urandom, 8'($urandom));
            send(CMD_NEIGHBOR, band_pos(i), 5'($urandom), band_pos(j), SIDE_BELOW,
                 $urandom, 8'($urandom));
         end
      for (int i = 0; i < 4; i++) begin
         send(CMD_NEIGHBOR, 5'($urandom), 5'($urandom), core_pos(i), SIDE_MX,
              $urandom, 8'($urandom));
         send(CMD_NEIGHBOR, 5'($urandom), 5'($urandom), core_pos(i), SIDE_PX,
              $urandom, 8'($urandom));
         send(CMD_NEIGHBOR, core_pos(i), 5'($urandom), 5'($urandom), SIDE_PZ,
              $urandom, 8'($urandom));
         send(CMD_NEIGHBOR, core_pos(i), 5'($urandom), 5'($urandom), SIDE_MZ,
              $urandom, 8'($urandom));
      end

      no_idle = 0;
      write_csr(CSR_SUBCHUNK, 4'd6);
      write_csr(CSR_PRESENT, 4'd15);
      send(CMD_COLUMN, 5'd0, 5'd0, 5'd0, SIDE_ABOVE, 32'hFFFF_FFFF, 8'd0);
      mesh(5'd0, 5'd0, 5'd0);
      mesh(5'd0, 5'd31, 5'd0);
      send(CMD_COLUMN, 5'd31, 5'd0, 5'd31, SIDE_ABOVE, 32'h8000_0001, 8'd0);
      send(CMD_TYPE, 5'd31, 5'd31, 5'd31, SIDE_ABOVE, 32'h0, 8'hFF);
      mesh(5'd31, 5'd31, 5'd31);
      mesh(5'd31, 5'd15, 5'd31);
      for (int i = 4; i <= 6; i++)
         for (int j = 4; j <= 6; j++)
            send(CMD_COLUMN, 5'(i), 5'd0, 5'(j), SIDE_ABOVE, 32'hFFFF_FFFF, 8'd0);
      send(CMD_NEIGHBOR, 5'd5, 5'd0, 5'd5, SIDE_ABOVE, 32'h1, 8'd0);
      send(CMD_NEIGHBOR, 5'd5, 5'd0, 5'd5, SIDE_BELOW, 32'h8000_0000, 8'd0);
      mesh(5'd5, 5'd10, 5'd5);
      mesh(5'd5, 5'd31, 5'd5);
      send(CMD_NEIGHBOR, 5'd5, 5'd0, 5'd5, SIDE_ABOVE, 32'h0, 8'd0);
      mesh(5'd5, 5'd31, 5'd5);
      send(CMD_NEIGHBOR, 5'd3, 5'd0, 5'd3, 3'd6, 32'hFFFF_FFFF, 8'd0);
      send(CMD_NEIGHBOR, 5'd3, 5'd0, 5'd3, 3'd7, 32'hFFFF_FFFF, 8'd0);

      phase_cfg = '{'{4'd0, 4'd0}, '{4'd6, 4'd15}, '{4'd3, 4'd5},
                    '{4'd1, 4'd10}, '{4'd6, 4'd0}, '{4'd0, 4'd15}};
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_SUBCHUNK, phase_cfg[p][0]);
         write_csr(CSR_PRESENT, phase_cfg[p][1]);
         no_idle = (p == 2);
         for (int k = 0; k < 32; k++) random_item();
      end
      no_idle = 0;
      go_quiet();
      $display("covered %0d mesh items, %0d vertices checked over six register settings",
               sb.meshes, sb.vertices);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d vertices missing", sb.errors, sb.pending.size());
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
